### hw/rtl/assert_macros.svh
// Assertion macros for the checker file of this project.
// Each macro expands to one labeled concurrent assertion that reports by error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define BHD_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BHD_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/bhd_pkg.sv
// ----------------------------------------------------------------------------
// BFS hop distance engine package
// Opcodes, status codes, register indexes and the control structs that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bhd_pkg;

	localparam int VERTEX_W = 8;
	localparam int HOP_W    = 8;

	localparam logic [1:0] OP_ADD_EDGE = 2'd0;
	localparam logic [1:0] OP_RUN      = 2'd1;
	localparam logic [1:0] OP_READ     = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [1:0] CFG_NUM_VERTICES = 2'd0;
	localparam logic [1:0] CFG_START_VERTEX = 2'd1;

	localparam logic [2:0] RES_ZERO  = 3'd0;
	localparam logic [2:0] RES_FULL  = 3'd1;
	localparam logic [2:0] RES_RANGE = 3'd2;
	localparam logic [2:0] RES_READ  = 3'd3;
	localparam logic [2:0] RES_RUN   = 3'd4;

	typedef struct packed {
		logic       in_ready;
		logic       sweep_head;
		logic       sweep_mark;
		logic       add_rd_head;
		logic       add_commit;
		logic       rd_mark_src;
		logic       seed;
		logic       pop;
		logic       fetch_vertex;
		logic       load_list;
		logic       edge_rd;
		logic       edge_take;
		logic       mark_rd_nx;
		logic       visit;
		logic       out_load;
		logic [2:0] res_sel;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       src_ok;
		logic       dst_ok;
		logic       start_ok;
		logic       full;
		logic       sweep_last;
		logic       q_more;
		logic       e_more;
		logic       nx_ok;
		logic       nx_marked;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

### hw/rtl/bhd_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one command word: opcode and two vertex numbers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bhd_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] source_vertex;
	logic [7:0] target_vertex;

	modport source (output valid, output opcode, output source_vertex,
		output target_vertex, input ready);
	modport sink (input valid, input opcode, input source_vertex,
		input target_vertex, output ready);
endinterface

`default_nettype wire

### hw/rtl/bhd_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one result word: status, hop count and reached flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bhd_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] hop_count;
	logic       reached;

	modport source (output valid, output status, output hop_count,
		output reached, input ready);
	modport sink (input valid, input status, input hop_count,
		input reached, output ready);
endinterface

`default_nettype wire

### hw/rtl/bfs_hop_distance_engine.sv
// Add edge: decode with a head read, commit, then the result word is loaded.
// Read distance: decode with a mark read, then the result word is loaded.
// Run search: decode, clear the marks, seed the start vertex, then pop, fetch and load
// the list of each dequeued vertex; read each edge and, for a valid target, its mark.
// One word is processed at a time; the result register lets the next word enter.
// After reset the list heads and marks are cleared first, address by address.
// ----------------------------------------------------------------------------
// BFS hop distance engine
// Graph store with breadth-first search of hop distances from a start vertex.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfs_hop_distance_engine #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_EDGES    = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	bhd_req_if.sink         req,
	bhd_rsp_if.source       rsp
);

	bhd_pkg::cmd_t cmd;
	bhd_pkg::sts_t sts;

	bhd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	bhd_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

### hw/rtl/bhd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bhd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/bhd_ctrl.sv
// ----------------------------------------------------------------------------
// BFS hop distance controller
// Sequences edge insertion, the search walk and distance reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bhd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire bhd_pkg::sts_t sts,
	output bhd_pkg::cmd_t      cmd
);

	localparam logic [3:0] S_INIT = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DISP = 4'd2;
	localparam logic [3:0] S_ADD  = 4'd3;
	localparam logic [3:0] S_CLR  = 4'd4;
	localparam logic [3:0] S_SEED = 4'd5;
	localparam logic [3:0] S_POP  = 4'd6;
	localparam logic [3:0] S_QW   = 4'd7;
	localparam logic [3:0] S_HW   = 4'd8;
	localparam logic [3:0] S_EC   = 4'd9;
	localparam logic [3:0] S_EW   = 4'd10;
	localparam logic [3:0] S_MW   = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	logic [3:0] state_q, state_d;
	logic [2:0] res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			res_q   <= bhd_pkg::RES_ZERO;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		res_d   = res_q;
		cmd.res_sel = res_q;
		case (state_q)
			S_INIT: begin
				cmd.sweep_head = 1'b1;
				cmd.sweep_mark = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (req_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_DONE;
				case (sts.op)
					bhd_pkg::OP_ADD_EDGE: begin
						if (!sts.src_ok || !sts.dst_ok) begin
							res_d = bhd_pkg::RES_RANGE;
						end else if (sts.full) begin
							res_d = bhd_pkg::RES_FULL;
						end else begin
							cmd.add_rd_head = 1'b1;
							state_d = S_ADD;
						end
					end
					bhd_pkg::OP_RUN: begin
						state_d = S_CLR;
					end
					bhd_pkg::OP_READ: begin
						if (!sts.src_ok) begin
							res_d = bhd_pkg::RES_RANGE;
						end else begin
							cmd.rd_mark_src = 1'b1;
							res_d = bhd_pkg::RES_READ;
						end
					end
					default: begin
						res_d = bhd_pkg::RES_ZERO;
					end
				endcase
			end
			S_ADD: begin
				cmd.add_commit = 1'b1;
				res_d   = bhd_pkg::RES_ZERO;
				state_d = S_DONE;
			end
			S_CLR: begin
				cmd.sweep_mark = 1'b1;
				if (sts.sweep_last) begin
					if (sts.start_ok) begin
						state_d = S_SEED;
					end else begin
						res_d   = bhd_pkg::RES_RANGE;
						state_d = S_DONE;
					end
				end
			end
			S_SEED: begin
				cmd.seed = 1'b1;
				state_d  = S_POP;
			end
			S_POP: begin
				if (sts.q_more) begin
					cmd.pop = 1'b1;
					state_d = S_QW;
				end else begin
					res_d   = bhd_pkg::RES_RUN;
					state_d = S_DONE;
				end
			end
			S_QW: begin
				cmd.fetch_vertex = 1'b1;
				state_d = S_HW;
			end
			S_HW: begin
				cmd.load_list = 1'b1;
				state_d = S_EC;
			end
			S_EC: begin
				if (sts.e_more) begin
					cmd.edge_rd = 1'b1;
					state_d = S_EW;
				end else begin
					state_d = S_POP;
				end
			end
			S_EW: begin
				cmd.edge_take = 1'b1;
				if (sts.nx_ok) begin
					cmd.mark_rd_nx = 1'b1;
					state_d = S_MW;
				end else begin
					state_d = S_EC;
				end
			end
			S_MW: begin
				cmd.visit = !sts.nx_marked;
				state_d = S_EC;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/bhd_datapath.sv
// ----------------------------------------------------------------------------
// BFS hop distance datapath
// Adjacency, mark, and queue memories with the pointers and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bhd_datapath #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_EDGES    = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [7:0]    cfg_data,
	input  wire bhd_pkg::cmd_t cmd,
	output bhd_pkg::sts_t      sts,
	bhd_req_if.sink            req,
	bhd_rsp_if.source          rsp
);

	localparam int VW     = $clog2(MAX_VERTICES);
	localparam int PW     = $clog2(MAX_VERTICES + 1);
	localparam int EW     = $clog2(MAX_EDGES);
	localparam int LW     = $clog2(MAX_EDGES + 1);
	localparam int MARK_W = 1 + bhd_pkg::HOP_W;
	localparam int EDGE_W = bhd_pkg::VERTEX_W + LW;

	logic [1:0]  op_q;
	logic [7:0]  src_q, dst_q, nv_q, start_q, nx_q, dcur_q;
	logic [LW-1:0] edges_q, link_q, steps_q;
	logic [VW-1:0] clr_q;
	logic [PW-1:0] rp_q, wp_q, cnt_q;
	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [7:0]  out_hop_q;
	logic        out_reached_q;

	logic [LW-1:0]     head_rdata;
	logic [EDGE_W-1:0] edge_rdata;
	logic [MARK_W-1:0] mark_rdata;
	logic [7:0]        q_rdata;
	logic [7:0]        e_tgt;
	logic [LW-1:0]     e_link;
	logic [7:0]        dnext;
	logic              sweep, q_room, out_free;

	function automatic logic vok(input logic [7:0] v, input logic [7:0] nv);
		return (v != 8'd0) && (v <= nv) && (32'(v) < MAX_VERTICES);
	endfunction

	assign sweep  = cmd.sweep_head | cmd.sweep_mark;
	assign e_tgt  = edge_rdata[EDGE_W-1 -: 8];
	assign e_link = edge_rdata[LW-1:0];
	assign dnext  = (dcur_q == 8'hFF) ? 8'hFF : dcur_q + 8'd1;
	assign q_room = 32'(wp_q) < MAX_VERTICES;
	assign out_free = !out_valid_q || rsp.ready;

	assign req.ready = cmd.in_ready;

	always_comb begin
		sts.op         = op_q;
		sts.src_ok     = vok(src_q, nv_q);
		sts.dst_ok     = vok(dst_q, nv_q);
		sts.start_ok   = vok(start_q, nv_q);
		sts.full       = edges_q == LW'(MAX_EDGES);
		sts.sweep_last = clr_q == VW'(MAX_VERTICES - 1);
		sts.q_more     = (rp_q < wp_q) && (32'(rp_q) < MAX_VERTICES);
		sts.e_more     = (link_q != '0) && (link_q <= edges_q) && (32'(steps_q) < MAX_EDGES);
		sts.nx_ok      = vok(e_tgt, nv_q);
		sts.nx_marked  = mark_rdata[MARK_W-1];
		sts.out_free   = out_free;
	end

	always_ff @(posedge clk) begin
		if (req.valid && cmd.in_ready) begin
			op_q  <= req.opcode;
			src_q <= req.source_vertex;
			dst_q <= req.target_vertex;
		end
		if (cmd.load_list) begin
			link_q <= head_rdata;
			dcur_q <= mark_rdata[7:0];
		end else if (cmd.edge_take) begin
			link_q <= e_link;
			nx_q   <= e_tgt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q     <= 8'd255;
			start_q  <= 8'd1;
			edges_q  <= '0;
			clr_q    <= '0;
			rp_q     <= '0;
			wp_q     <= '0;
			cnt_q    <= '0;
			steps_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == bhd_pkg::CFG_NUM_VERTICES) begin
				nv_q <= cfg_data;
			end
			if (cfg_we && cfg_index == bhd_pkg::CFG_START_VERTEX) begin
				start_q <= cfg_data;
			end
			if (cmd.add_commit) begin
				edges_q <= edges_q + LW'(1);
			end
			if (sweep) begin
				clr_q <= sts.sweep_last ? '0 : clr_q + VW'(1);
			end
			if (cmd.seed) begin
				rp_q  <= '0;
				wp_q  <= PW'(1);
				cnt_q <= PW'(1);
			end else begin
				if (cmd.pop) begin
					rp_q <= rp_q + PW'(1);
				end
				if (cmd.visit) begin
					cnt_q <= cnt_q + PW'(1);
					if (q_room) begin
						wp_q <= wp_q + PW'(1);
					end
				end
			end
			if (cmd.load_list) begin
				steps_q <= '0;
			end else if (cmd.edge_rd) begin
				steps_q <= steps_q + LW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q  <= bhd_pkg::ST_OK;
			out_hop_q     <= 8'd0;
			out_reached_q <= 1'b0;
			case (cmd.res_sel)
				bhd_pkg::RES_FULL: begin
					out_status_q <= bhd_pkg::ST_FULL;
				end
				bhd_pkg::RES_RANGE: begin
					out_status_q <= bhd_pkg::ST_RANGE;
				end
				bhd_pkg::RES_READ: begin
					out_reached_q <= mark_rdata[MARK_W-1];
					out_hop_q     <= mark_rdata[MARK_W-1] ? mark_rdata[7:0] : 8'd0;
				end
				bhd_pkg::RES_RUN: begin
					out_hop_q <= (32'(cnt_q) > 255) ? 8'hFF : 8'(cnt_q);
				end
				default: begin
					out_status_q <= bhd_pkg::ST_OK;
				end
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.hop_count = out_hop_q;
	assign rsp.reached   = out_reached_q;

	bhd_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_head (
		.clk   (clk),
		.we    (cmd.sweep_head | cmd.add_commit),
		.waddr (cmd.sweep_head ? clr_q : VW'(src_q)),
		.wdata (cmd.sweep_head ? '0 : edges_q + LW'(1)),
		.re    (cmd.add_rd_head | cmd.fetch_vertex),
		.raddr (cmd.fetch_vertex ? VW'(q_rdata) : VW'(src_q)),
		.rdata (head_rdata)
	);

	bhd_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge (
		.clk   (clk),
		.we    (cmd.add_commit),
		.waddr (edges_q[EW-1:0]),
		.wdata ({dst_q, head_rdata}),
		.re    (cmd.edge_rd),
		.raddr (EW'(link_q - LW'(1))),
		.rdata (edge_rdata)
	);

	bhd_ram #(.WIDTH(MARK_W), .DEPTH(MAX_VERTICES)) u_mark (
		.clk   (clk),
		.we    (cmd.sweep_mark | cmd.seed | cmd.visit),
		.waddr (cmd.sweep_mark ? clr_q : (cmd.seed ? VW'(start_q) : VW'(nx_q))),
		.wdata (cmd.sweep_mark ? '0 : {1'b1, (cmd.seed ? 8'd0 : dnext)}),
		.re    (cmd.rd_mark_src | cmd.fetch_vertex | cmd.mark_rd_nx),
		.raddr (cmd.fetch_vertex ? VW'(q_rdata) :
			(cmd.mark_rd_nx ? VW'(e_tgt) : VW'(src_q))),
		.rdata (mark_rdata)
	);

	bhd_ram #(.WIDTH(8), .DEPTH(MAX_VERTICES)) u_queue (
		.clk   (clk),
		.we    (cmd.seed | (cmd.visit & q_room)),
		.waddr (cmd.seed ? '0 : wp_q[VW-1:0]),
		.wdata (cmd.seed ? start_q : nx_q),
		.re    (cmd.pop),
		.raddr (rp_q[VW-1:0]),
		.rdata (q_rdata)
	);

endmodule

`default_nettype wire

### hw/rtl/bhd_checker.sv
// ----------------------------------------------------------------------------
// BFS hop distance port checker
// Watches the channel ports and checks ordering of words over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bhd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready
);

	logic [1:0] pend_q;
	logic       req_acc, rsp_acc;

	assign req_acc = req_valid & req_ready;
	assign rsp_acc = rsp_valid & rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + {1'b0, req_acc} - {1'b0, rsp_acc};
		end
	end

	`BHD_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid, "response word dropped while stalled")
	`BHD_ASSERT(a_one_at_a_time, clk, arst_n, req_acc |=> !req_ready, "request taken while a word is in work")
	`BHD_ASSERT(a_no_invented, clk, arst_n, rsp_valid |-> pend_q != 2'd0, "response word without a request word")
	`BHD_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !rsp_valid, "response valid during reset")

endmodule

bind bfs_hop_distance_engine bhd_checker u_bhd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready)
);

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// BFS hop distance engine testbench
// Drives edge adds, searches and distance reads through the request channel
// and checks every result word against a table row or a built-in graph model.
// A directed table comes first, then random phases under several register
// settings, ending with a phase that fills the edge store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int NV_MAX = 256;
	localparam int NE_MAX = 1024;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int N_PHASES = 12;

	typedef struct {
		logic [1:0] status;
		logic [7:0] hop;
		logic       reached;
	} rsp_word_t;

	typedef struct {
		logic [1:0] op;
		logic [7:0] src;
		logic [7:0] dst;
		bit         typed;
		logic [1:0] status;
		logic [7:0] hop;
		logic       reached;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b1;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	bhd_req_if req ();
	bhd_rsp_if rsp ();

	bfs_hop_distance_engine i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp)
	);

	int        g_nv = 255;
	int        g_start = 1;
	int        g_head [NV_MAX];
	int        g_tgt [NE_MAX];
	int        g_lnk [NE_MAX];
	int        g_edges = 0;
	bit        g_mark [NV_MAX];
	int        g_dist [NV_MAX];
	int        g_queue [NV_MAX];
	rsp_word_t pending_rsp [$];
	int        words_sent = 0;
	int        errors = 0;
	int        cycles = 0;
	bit        hold_done = 0;
	int        hold_left = 0;
	dir_row_t  dir_tab [19];
	int        nv_set [N_PHASES] = '{10, 255, 1, 4, 255, 30, 255, 8, 255, 64, 16, 255};
	int        st_set [N_PHASES] = '{2, 1, 1, 0, 255, 31, 7, 3, 200, 5, 9, 1};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0;
		req.opcode = '0;
		req.source_vertex = '0;
		req.target_vertex = '0;
		rsp.ready = 1'b0;
		foreach (g_head[i]) begin
			g_head[i] = 0;
			g_mark[i] = 0;
			g_dist[i] = 0;
		end
	end

	function automatic bit vertex_ok(int v);
		return v >= 1 && v <= g_nv && v < NV_MAX;
	endfunction

	function automatic rsp_word_t graph_step(logic [1:0] op, logic [7:0] s, logic [7:0] t);
		rsp_word_t r;
		int        link, cur, nx, cnt, steps, rp, wp;
		r = '{bhd_pkg::ST_OK, 8'd0, 1'b0};
		if (op == bhd_pkg::OP_ADD_EDGE) begin
			if (!vertex_ok(int'(s)) || !vertex_ok(int'(t))) begin
				r.status = bhd_pkg::ST_RANGE;
			end else if (g_edges >= NE_MAX) begin
				r.status = bhd_pkg::ST_FULL;
			end else begin
				g_tgt[g_edges] = int'(t);
				g_lnk[g_edges] = g_head[s];
				g_head[s] = g_edges + 1;
				g_edges++;
			end
		end else if (op == bhd_pkg::OP_RUN) begin
			foreach (g_mark[i])
				g_mark[i] = 0;
			if (!vertex_ok(g_start)) begin
				r.status = bhd_pkg::ST_RANGE;
			end else begin
				g_mark[g_start] = 1;
				g_dist[g_start] = 0;
				g_queue[0] = g_start;
				rp = 0;
				wp = 1;
				cnt = 1;
				while (rp < wp && rp < NV_MAX) begin
					cur = g_queue[rp];
					rp++;
					link = g_head[cur];
					steps = 0;
					while (link != 0 && link <= g_edges && steps < NE_MAX) begin
						nx = g_tgt[link - 1];
						link = g_lnk[link - 1];
						steps++;
						if (vertex_ok(nx) && !g_mark[nx]) begin
							g_mark[nx] = 1;
							g_dist[nx] = (g_dist[cur] + 1 > 255) ? 255 : g_dist[cur] + 1;
							if (wp < NV_MAX) begin
								g_queue[wp] = nx;
								wp++;
							end
							cnt++;
						end
					end
				end
				r.hop = (cnt > 255) ? 8'd255 : cnt[7:0];
			end
		end else if (op == bhd_pkg::OP_READ) begin
			if (!vertex_ok(int'(s))) begin
				r.status = bhd_pkg::ST_RANGE;
			end else if (g_mark[s]) begin
				r.hop = g_dist[s][7:0];
				r.reached = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic send_word(logic [1:0] op, logic [7:0] s, logic [7:0] t,
			bit typed = 0, rsp_word_t typed_rsp = '{bhd_pkg::ST_OK, 8'd0, 1'b0});
		bit        quiet;
		rsp_word_t r;
		quiet = words_sent >= 400 && words_sent < 560;
		if (!quiet && $urandom_range(0, 99) < 25) begin
			req.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req.opcode = op;
		req.source_vertex = s;
		req.target_vertex = t;
		req.valid = 1'b1;
		do
			@(posedge clk);
		while (!req.ready);
		r = graph_step(op, s, t);
		pending_rsp.push_back(typed ? typed_rsp : r);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int value);
		req.valid = 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (8) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value[7:0];
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == bhd_pkg::CFG_NUM_VERTICES)
			g_nv = value & 255;
		else
			g_start = value & 255;
	endtask

	function automatic logic [7:0] pick_vertex();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return 8'($urandom_range(1, g_nv));
		else if (r < 95)
			return 8'($urandom_range(0, 255));
		else
			return 8'((g_nv + 1) & 255);
	endfunction

	task automatic random_word();
		int         r;
		logic [1:0] op;
		r = $urandom_range(0, 99);
		if (r < 76)
			op = bhd_pkg::OP_ADD_EDGE;
		else if (r < 91)
			op = bhd_pkg::OP_READ;
		else if (r < 96)
			op = bhd_pkg::OP_RUN;
		else
			op = 2'($urandom_range(0, 3));
		send_word(op, pick_vertex(), pick_vertex());
	endtask

	always @(negedge clk) begin
		if (!hold_done && words_sent >= 700) begin
			hold_done = 1;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready = 1'b0;
		end else begin
			rsp.ready = (words_sent >= 400 && words_sent < 560) ||
				$urandom_range(0, 99) >= 25;
		end
	end

	always @(posedge clk) begin
		rsp_word_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected word: status %0d hop %0d reached %0d",
					$time, rsp.status, rsp.hop_count, rsp.reached);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
					errors++;
				end
				if (rsp.hop_count !== e.hop) begin
					$display("%0t: hop_count expected %0d actual %0d", $time, e.hop,
						rsp.hop_count);
					errors++;
				end
				if (rsp.reached !== e.reached) begin
					$display("%0t: reached expected %0d actual %0d", $time, e.reached,
						rsp.reached);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		dir_tab = '{
			'{bhd_pkg::OP_READ, 8'd5, 8'd0, 1, bhd_pkg::ST_OK, 8'd0, 1'b0},
			'{bhd_pkg::OP_READ, 8'd0, 8'd0, 1, bhd_pkg::ST_RANGE, 8'd0, 1'b0},
			'{bhd_pkg::OP_ADD_EDGE, 8'd0, 8'd3, 1, bhd_pkg::ST_RANGE, 8'd0, 1'b0},
			'{bhd_pkg::OP_ADD_EDGE, 8'd3, 8'd0, 1, bhd_pkg::ST_RANGE, 8'd0, 1'b0},
			'{bhd_pkg::OP_RUN, 8'd0, 8'd0, 1, bhd_pkg::ST_OK, 8'd1, 1'b0},
			'{bhd_pkg::OP_READ, 8'd1, 8'd0, 1, bhd_pkg::ST_OK, 8'd0, 1'b1},
			'{2'd3, 8'd255, 8'd255, 1, bhd_pkg::ST_OK, 8'd0, 1'b0},
			'{bhd_pkg::OP_ADD_EDGE, 8'd1, 8'd255, 1, bhd_pkg::ST_OK, 8'd0, 1'b0},
			'{bhd_pkg::OP_ADD_EDGE, 8'd255, 8'd2, 1, bhd_pkg::ST_OK, 8'd0, 1'b0},
			'{bhd_pkg::OP_ADD_EDGE, 8'd2, 8'd1, 1, bhd_pkg::ST_OK, 8'd0, 1'b0},
			'{bhd_pkg::OP_ADD_EDGE, 8'd2, 8'd200, 1, bhd_pkg::ST_OK, 8'd0, 1'b0},
			'{bhd_pkg::OP_READ, 8'd255, 8'd0, 1, bhd_pkg::ST_OK, 8'd0, 1'b0},
			'{bhd_pkg::OP_RUN, 8'd0, 8'd0, 0, bhd_pkg::ST_OK, 8'd0, 1'b0},
			'{bhd_pkg::OP_READ, 8'd255, 8'd0, 0, bhd_pkg::ST_OK, 8'd0, 1'b0},
			'{bhd_pkg::OP_READ, 8'd200, 8'd0, 0, bhd_pkg::ST_OK, 8'd0, 1'b0},
			'{bhd_pkg::OP_READ, 8'd254, 8'd0, 1, bhd_pkg::ST_OK, 8'd0, 1'b0},
			'{bhd_pkg::OP_ADD_EDGE, 8'd170, 8'd85, 1, bhd_pkg::ST_OK, 8'd0, 1'b0},
			'{bhd_pkg::OP_ADD_EDGE, 8'd85, 8'd170, 1, bhd_pkg::ST_OK, 8'd0, 1'b0},
			'{bhd_pkg::OP_READ, 8'd2, 8'd0, 0, bhd_pkg::ST_OK, 8'd0, 1'b0}
		};
		#1 arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		write_reg(bhd_pkg::CFG_NUM_VERTICES, 255);
		write_reg(bhd_pkg::CFG_START_VERTEX, 1);
		foreach (dir_tab[i])
			send_word(dir_tab[i].op, dir_tab[i].src, dir_tab[i].dst, dir_tab[i].typed,
				'{dir_tab[i].status, dir_tab[i].hop, dir_tab[i].reached});
		for (int p = 0; p < N_PHASES; p++) begin
			write_reg(bhd_pkg::CFG_NUM_VERTICES, nv_set[p]);
			write_reg(bhd_pkg::CFG_START_VERTEX, st_set[p]);
			send_word(bhd_pkg::OP_RUN, 8'd0, 8'd0);
			repeat (90)
				random_word();
			send_word(bhd_pkg::OP_RUN, 8'd0, 8'd0);
		end
		write_reg(bhd_pkg::CFG_NUM_VERTICES, 255);
		write_reg(bhd_pkg::CFG_START_VERTEX, 1);
		while (g_edges < NE_MAX) begin
			send_word(bhd_pkg::OP_ADD_EDGE, 8'($urandom_range(1, 255)),
				8'($urandom_range(1, 255)));
			if ($urandom_range(0, 99) < 3)
				send_word(bhd_pkg::OP_RUN, 8'd0, 8'd0);
		end
		repeat (10)
			send_word(bhd_pkg::OP_ADD_EDGE, 8'($urandom_range(1, 255)),
				8'($urandom_range(1, 255)));
		send_word(bhd_pkg::OP_ADD_EDGE, 8'd0, 8'd5);
		send_word(bhd_pkg::OP_RUN, 8'd0, 8'd0);
		repeat (20)
			send_word(bhd_pkg::OP_READ, 8'($urandom_range(0, 255)), 8'd0);
		req.valid = 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
